// ----- design/jsu_pkg.sv -----
package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       run_end;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STR     = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX     = 4'd3,
    PH_PAIR_BS = 4'd4,
    PH_PAIR_U  = 4'd5,
    PH_LOW_HEX = 4'd6,
    PH_DRAIN   = 4'd7
  } phase_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
  localparam logic [2:0] ERR_ESCAPE_CUT   = 3'd2;
  localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_SHORT_HEX    = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX      = 3'd5;
  localparam logic [2:0] ERR_BAD_PAIR     = 3'd6;
  localparam logic [2:0] ERR_LONE_LOW     = 3'd7;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;

  localparam logic [20:0] CP_1B_MAX = 21'h00007F;
  localparam logic [20:0] CP_2B_MAX = 21'h0007FF;
  localparam logic [20:0] CP_3B_MAX = 21'h00FFFF;
  localparam logic [20:0] CP_PLANE1 = 21'h010000;

  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] CONT_B  = 8'h80;

  // Bit 4 set marks a byte that is not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39)      d = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) d = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) d = {1'b0, 4'(c - 8'h37)};
    return d;
  endfunction

  // Return {simple_ok, byte}; simple_ok clear for anything but a simple escape.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    r = 9'h000;
    case (c)
      8'h22: r = {1'b1, 8'h22};
      8'h5C: r = {1'b1, 8'h5C};
      8'h2F: r = {1'b1, 8'h2F};
      8'h62: r = {1'b1, 8'h08};
      8'h66: r = {1'b1, 8'h0C};
      8'h6E: r = {1'b1, 8'h0A};
      8'h72: r = {1'b1, 8'h0D};
      8'h74: r = {1'b1, 8'h09};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

// ----- design/json_string_unescape_utf8.sv -----
// Latency: results of a byte appear at the output the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and res_stall
//   is low; a byte that gives more (up to four UTF-8 bytes of a code point) stalls the
//   input until its last result leaves, and the next byte is taken in that cycle.
// Reset: decoder waits for an opening quote; result buffer empty.
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_data,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_data
);

  phase_t      phase, phase_next;
  logic [15:0] hex_value, hex_value_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [9:0]  high_bits, high_bits_next;
  logic        bad_hex, bad_hex_next;

  // result buffer for one accepted beat
  logic [2:0]  cnt;
  logic [1:0]  idx;
  logic [7:0]  bytes [4];
  logic [1:0]  res_kind;
  logic [2:0]  res_err;

  logic [2:0]  cnt_next;
  logic [7:0]  bytes_next [4];
  logic [1:0]  kind_next;
  logic [2:0]  err_next;

  logic accept, pop, last_pop, pend;

  assign pend       = (cnt != 3'd0);
  assign res_valid  = pend;
  assign pop        = pend && !res_stall;
  assign last_pop   = pop && ({1'b0, idx} == cnt - 3'd1);
  assign byte_stall = pend && !last_pop;
  assign accept     = byte_valid && !byte_stall;

  assign res_data.out_byte   = (res_kind == KIND_DATA) ? bytes[idx] : 8'h00;
  assign res_data.kind       = res_kind;
  assign res_data.error_code = res_err;
  assign res_data.run_end    = ({1'b0, idx} == cnt - 3'd1);

  logic [7:0]  b;
  logic        last;
  logic [4:0]  dig;
  logic [8:0]  simp;
  logic [15:0] hv;
  logic [20:0] cp;
  logic        raise, close, emit_cp, emit_byte;
  logic [2:0]  rcode;

  always_comb begin
    b    = byte_data.in_byte;
    last = byte_data.last_byte;
    dig  = hex_digit(b);
    simp = simple_escape(b);
    hv   = dig[4] ? hex_value : {hex_value[11:0], dig[3:0]};
    cp   = {5'd0, hv};

    phase_next       = phase;
    hex_value_next   = hex_value;
    digit_count_next = digit_count;
    high_bits_next   = high_bits;
    bad_hex_next     = bad_hex;

    raise     = 1'b0;
    rcode     = ERR_NO_QUOTE;
    close     = 1'b0;
    emit_cp   = 1'b0;
    emit_byte = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (b == CH_QUOTE) begin
          if (last) begin
            raise = 1'b1;
            rcode = ERR_UNTERMINATED;
          end else begin
            phase_next = PH_STR;
          end
        end else begin
          raise = 1'b1;
          rcode = ERR_NO_QUOTE;
        end
      end
      PH_STR: begin
        if (b == CH_QUOTE) begin
          close      = 1'b1;
          phase_next = PH_IDLE;
        end else if (last) begin
          raise = 1'b1;
          rcode = (b == CH_BSL) ? ERR_ESCAPE_CUT : ERR_UNTERMINATED;
        end else if (b == CH_BSL) begin
          phase_next = PH_ESC;
        end else begin
          emit_byte = 1'b1;
        end
      end
      PH_ESC: begin
        if (simp[8]) begin
          if (last) begin
            raise = 1'b1;
            rcode = ERR_UNTERMINATED;
          end else begin
            emit_byte  = 1'b1;
            phase_next = PH_STR;
          end
        end else if (b == CH_U) begin
          if (last) begin
            raise = 1'b1;
            rcode = ERR_SHORT_HEX;
          end else begin
            hex_value_next   = 16'h0000;
            digit_count_next = 2'd0;
            bad_hex_next     = 1'b0;
            phase_next       = PH_HEX;
          end
        end else begin
          raise = 1'b1;
          rcode = ERR_BAD_ESCAPE;
        end
      end
      PH_HEX, PH_LOW_HEX: begin
        bad_hex_next   = bad_hex | dig[4];
        hex_value_next = hv;
        if (digit_count != 2'd3) begin
          if (last) begin
            raise = 1'b1;
            rcode = ERR_SHORT_HEX;
          end else begin
            digit_count_next = digit_count + 2'd1;
          end
        end else begin
          digit_count_next = 2'd0;
          if (bad_hex_next) begin
            raise = 1'b1;
            rcode = ERR_BAD_HEX;
          end else if (phase == PH_HEX) begin
            if (hv >= HIGH_SUR_LO && hv <= HIGH_SUR_HI) begin
              if (last) begin
                raise = 1'b1;
                rcode = ERR_BAD_PAIR;
              end else begin
                high_bits_next = hv[9:0];
                phase_next     = PH_PAIR_BS;
              end
            end else if (hv >= LOW_SUR_LO && hv <= LOW_SUR_HI) begin
              raise = 1'b1;
              rcode = ERR_LONE_LOW;
            end else begin
              emit_cp = 1'b1;
            end
          end else begin
            if (hv < LOW_SUR_LO || hv > LOW_SUR_HI) begin
              raise = 1'b1;
              rcode = ERR_BAD_PAIR;
            end else begin
              cp      = CP_PLANE1 + {1'b0, high_bits, hv[9:0]};
              emit_cp = 1'b1;
            end
          end
          if (emit_cp && last) begin
            emit_cp = 1'b0;
            raise   = 1'b1;
            rcode   = ERR_UNTERMINATED;
          end else if (emit_cp) begin
            phase_next = PH_STR;
          end
        end
      end
      PH_PAIR_BS: begin
        if (last || b != CH_BSL) begin
          raise = 1'b1;
          rcode = ERR_BAD_PAIR;
        end else begin
          phase_next = PH_PAIR_U;
        end
      end
      PH_PAIR_U: begin
        if (b != CH_U) begin
          raise = 1'b1;
          rcode = ERR_BAD_PAIR;
        end else if (last) begin
          raise = 1'b1;
          rcode = ERR_SHORT_HEX;
        end else begin
          hex_value_next   = 16'h0000;
          digit_count_next = 2'd0;
          bad_hex_next     = 1'b0;
          phase_next       = PH_LOW_HEX;
        end
      end
      default: begin
        phase_next = last ? PH_IDLE : PH_DRAIN;
      end
    endcase

    if (raise) phase_next = last ? PH_IDLE : PH_DRAIN;

    // assemble the result beats
    cnt_next   = 3'd0;
    kind_next  = KIND_DATA;
    err_next   = 3'd0;
    for (int i = 0; i < 4; i++) bytes_next[i] = 8'h00;
    if (raise) begin
      cnt_next  = 3'd1;
      kind_next = KIND_ERROR;
      err_next  = rcode;
    end else if (close) begin
      cnt_next  = 3'd1;
      kind_next = KIND_CLOSE;
    end else if (emit_byte) begin
      cnt_next      = 3'd1;
      bytes_next[0] = (phase == PH_ESC) ? simp[7:0] : b;
    end else if (emit_cp) begin
      if (cp <= CP_1B_MAX) begin
        cnt_next      = 3'd1;
        bytes_next[0] = {1'b0, cp[6:0]};
      end else if (cp <= CP_2B_MAX) begin
        cnt_next      = 3'd2;
        bytes_next[0] = LEAD_2B | {3'b000, cp[10:6]};
        bytes_next[1] = CONT_B | {2'b00, cp[5:0]};
      end else if (cp <= CP_3B_MAX) begin
        cnt_next      = 3'd3;
        bytes_next[0] = LEAD_3B | {4'h0, cp[15:12]};
        bytes_next[1] = CONT_B | {2'b00, cp[11:6]};
        bytes_next[2] = CONT_B | {2'b00, cp[5:0]};
      end else begin
        cnt_next      = 3'd4;
        bytes_next[0] = LEAD_4B | {5'd0, cp[20:18]};
        bytes_next[1] = CONT_B | {2'b00, cp[17:12]};
        bytes_next[2] = CONT_B | {2'b00, cp[11:6]};
        bytes_next[3] = CONT_B | {2'b00, cp[5:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      hex_value   <= 16'h0000;
      digit_count <= 2'd0;
      high_bits   <= 10'd0;
      bad_hex     <= 1'b0;
      cnt         <= 3'd0;
      idx         <= 2'd0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        hex_value   <= hex_value_next;
        digit_count <= digit_count_next;
        high_bits   <= high_bits_next;
        bad_hex     <= bad_hex_next;
        cnt         <= cnt_next;
        idx         <= 2'd0;
      end else if (last_pop) begin
        cnt <= 3'd0;
        idx <= 2'd0;
      end else if (pop) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // payload of the result buffer: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) bytes[i] <= bytes_next[i];
      res_kind <= kind_next;
      res_err  <= err_next;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    pend |-> ({1'b0, idx} < cnt))
    else $error("result index past buffer count");

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("result buffer count above four");

  a_marker_single: assert property (@(posedge clk) disable iff (rst)
    (pend && res_kind != KIND_DATA) |-> (cnt == 3'd1))
    else $error("end or error beat not alone");

  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_DRAIN) |=> (cnt == 3'd0))
    else $error("byte gave a result while skipping after an error");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (pend && !last_pop) |-> !accept)
    else $error("byte accepted while results still queued");

endmodule
